// File: rtl/iqfpt_pkg.sv
// shared types, constants and the cordic arctangent table for the fringe tracker
// no dependencies
package iqfpt_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  // cordic vector and angle width (angle in turns, 32 fraction bits)
  localparam int CW = 35;

  localparam logic signed [CW-1:0] TURN_HALF    = 35'sd2147483648;
  localparam logic signed [CW-1:0] TURN_QUARTER = 35'sd1073741824;

  localparam logic [16:0] GAIN_RESET = 17'd1311;
  localparam logic [16:0] GAIN_ONE   = 17'd65536;

  localparam logic CFG_GAIN   = 1'b0;
  localparam logic CFG_OFFSET = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_FRAC,
    ST_MUL,
    ST_AVG,
    ST_POS
  } iqfpt_state_t;

  typedef struct packed {
    logic              load;
    logic              rot;
    logic              frac;
    logic              mul;
    logic              avg;
    logic              pos;
    logic [STEP_W-1:0] step;
  } iqfpt_cmd_t;

  // atan(2^-k) / (2 pi) in turns, scaled by 2^32
  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    logic [31:0] r;
    case (k)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/iqfpt_ctrl.sv
// sequencing state machine for the fringe tracker
// uses iqfpt_pkg; drives the datapath through iqfpt_cmd_t
module iqfpt_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  output iqfpt_pkg::iqfpt_cmd_t   cmd
);
  import iqfpt_pkg::*;

  iqfpt_state_t      state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.step      = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_ROT;
        end
      end
      ST_ROT: begin
        cmd.rot  = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          state_nxt = ST_FRAC;
        end
      end
      ST_FRAC: begin
        cmd.frac  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_AVG;
      end
      ST_AVG: begin
        cmd.avg   = 1'b1;
        state_nxt = ST_POS;
      end
      ST_POS: begin
        // output slot free or being emptied at this edge
        if (!out_valid_r || !out_stall) begin
          cmd.pos       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/iqfpt_datapath.sv
// turn counter, iterative cordic, smoothing filter and position scaling
// uses iqfpt_pkg; sequenced by iqfpt_ctrl
module iqfpt_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  iqfpt_pkg::iqfpt_cmd_t   cmd,
  input  logic [15:0]             in_i_sample,
  input  logic [15:0]             in_q_sample,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_index,
  input  logic [16:0]             cfg_data,
  output logic signed [47:0]      out_position,
  output logic signed [23:0]      out_turn_count,
  output logic signed [15:0]      out_phase_fraction
);
  import iqfpt_pkg::*;

  localparam int TW = 24 + FRAC_BITS + 1;
  localparam int DW = TW + 1;
  localparam int HW = DW - 16;
  localparam logic signed [CW-1:0] FRAC_RND = CW'(64'sd1 <<< (31 - FRAC_BITS));
  localparam logic signed [53:0] AVG_MAX = 54'sd140737488355327;
  localparam logic signed [53:0] AVG_MIN = -54'sd140737488355328;
  localparam logic signed [63:0] POS_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] POS_MIN = -64'sd140737488355328;

  // configuration and tracking state
  logic [16:0]        gain_r;
  logic signed [15:0] zero_off_r;
  logic signed [23:0] turns_r, turns_nxt;
  logic               q_neg_r;
  logic signed [47:0] smooth_r, smooth_nxt;

  // working registers
  logic signed [CW-1:0]        x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic signed [HW-1:0]        hi_r;
  logic [15:0]                 lo_r;
  logic signed [15:0]          pf_r, pf_nxt;
  logic signed [51:0]          ph_r;
  logic [32:0]                 pl_r;
  logic signed [CW-1:0]        x_ld, y_ld, z_ld;

  logic signed [15:0]   i_s, q_s;
  logic signed [CW-1:0] ix, qx;
  logic                 i_neg, q_neg;

  assign i_s   = {~in_i_sample[15], in_i_sample[14:0]};
  assign q_s   = {~in_q_sample[15], in_q_sample[14:0]};
  assign ix    = CW'(i_s) <<< 16;
  assign qx    = CW'(q_s) <<< 16;
  assign i_neg = i_s[15];
  assign q_neg = q_s[15];

  // turn counting
  always_comb begin
    turns_nxt = turns_r;
    if (i_neg) begin
      if (!q_neg && q_neg_r && (turns_r != 24'sh800000)) begin
        turns_nxt = turns_r - 24'sd1;
      end
      if (q_neg && !q_neg_r && (turns_r != 24'sh7fffff)) begin
        turns_nxt = turns_r + 24'sd1;
      end
    end
  end

  // cordic start vector; axis samples get the exact angle and a zero vector
  always_comb begin
    x_ld = '0;
    y_ld = '0;
    z_ld = '0;
    if (q_s == 16'sd0) begin
      z_ld = i_neg ? TURN_HALF : '0;
    end else if (i_s == 16'sd0) begin
      z_ld = q_neg ? -TURN_QUARTER : TURN_QUARTER;
    end else if (!i_neg) begin
      x_ld = ix;
      y_ld = qx;
    end else if (!q_neg) begin
      x_ld = qx;
      y_ld = -ix;
      z_ld = TURN_QUARTER;
    end else begin
      x_ld = -qx;
      y_ld = ix;
      z_ld = -TURN_QUARTER;
    end
  end

  // one rotation per cycle
  logic signed [CW-1:0] dx, dy, at;
  assign dx = y_r >>> cmd.step;
  assign dy = x_r >>> cmd.step;
  assign at = $signed({3'b000, atan_turn(5'(cmd.step))});

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (cmd.load) begin
      x_nxt = x_ld;
      y_nxt = y_ld;
      z_nxt = z_ld;
    end else if (cmd.rot) begin
      if (y_r > 0) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end else if (y_r < 0) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end
    end
  end

  // fraction, total and filter difference
  logic signed [CW-1:0] zc, frac_w, pf_w;
  logic signed [TW-1:0] total;
  logic signed [DW-1:0] diff;

  always_comb begin
    if (z_r > TURN_HALF) begin
      zc = TURN_HALF;
    end else if (z_r < -TURN_HALF) begin
      zc = -TURN_HALF;
    end else begin
      zc = z_r;
    end
    frac_w = (zc + FRAC_RND) >>> (32 - FRAC_BITS);
    total  = (TW'(turns_r) <<< FRAC_BITS) + TW'($signed(frac_w[FRAC_BITS+1:0]));
    diff   = DW'(total) - DW'(smooth_r);
    pf_w   = (zc + 35'sd32768) >>> 16;
    if (pf_w > 35'sd32767) begin
      pf_nxt = 16'sh7fff;
    end else if (pf_w < -35'sd32768) begin
      pf_nxt = 16'sh8000;
    end else begin
      pf_nxt = pf_w[15:0];
    end
  end

  // gain products and filter update
  logic [16:0]        gain_eff;
  logic signed [51:0] ph_nxt;
  logic [32:0]        pl_nxt, pl_rnd;
  logic signed [53:0] avg_sum;

  always_comb begin
    gain_eff = (gain_r > GAIN_ONE) ? GAIN_ONE : gain_r;
    ph_nxt   = $signed({1'b0, gain_eff}) * hi_r;
    pl_nxt   = 33'(gain_eff) * 33'(lo_r);
    pl_rnd   = pl_r + 33'd32768;
    avg_sum  = 54'(smooth_r) + 54'(ph_r) + 54'($signed({1'b0, pl_rnd[32:16]}));
    if (avg_sum > AVG_MAX) begin
      smooth_nxt = 48'sh7fffffffffff;
    end else if (avg_sum < AVG_MIN) begin
      smooth_nxt = 48'sh800000000000;
    end else begin
      smooth_nxt = avg_sum[47:0];
    end
  end

  // offset, scale by -17/4 mm per turn, position
  logic signed [48:0] off, d;
  logic signed [55:0] v;
  logic signed [63:0] pos_w;
  logic signed [47:0] pos_nxt;

  generate
    if (FRAC_BITS >= 16) begin : g_off_up
      assign off = 49'(zero_off_r) <<< (FRAC_BITS - 16);
    end else begin : g_off_dn
      localparam logic signed [16:0] OFF_RND = 17'(32'sd1 <<< (15 - FRAC_BITS));
      logic signed [16:0] off_s;
      assign off_s = (17'(zero_off_r) + OFF_RND) >>> (16 - FRAC_BITS);
      assign off   = 49'(off_s);
    end
  endgenerate

  assign d = 49'(smooth_r) - off;
  assign v = -((56'(d) <<< 4) + 56'(d));

  generate
    if (FRAC_BITS > 14) begin : g_pos_dn
      localparam logic signed [63:0] POS_RND = 64'sd1 <<< (FRAC_BITS - 15);
      assign pos_w = (64'(v) + POS_RND) >>> (FRAC_BITS - 14);
    end else begin : g_pos_up
      assign pos_w = 64'(v) <<< (14 - FRAC_BITS);
    end
  endgenerate

  always_comb begin
    if (pos_w > POS_MAX) begin
      pos_nxt = 48'sh7fffffffffff;
    end else if (pos_w < POS_MIN) begin
      pos_nxt = 48'sh800000000000;
    end else begin
      pos_nxt = pos_w[47:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= GAIN_RESET;
      zero_off_r <= '0;
      turns_r    <= '0;
      q_neg_r    <= 1'b0;
      smooth_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_GAIN:   gain_r     <= cfg_data;
          CFG_OFFSET: zero_off_r <= cfg_data[15:0];
          default:    gain_r     <= gain_r;
        endcase
      end
      if (cmd.load) begin
        turns_r <= turns_nxt;
        q_neg_r <= q_neg;
      end
      if (cmd.avg) begin
        smooth_r <= smooth_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    if (cmd.frac) begin
      hi_r <= diff[DW-1:16];
      lo_r <= diff[15:0];
      pf_r <= pf_nxt;
    end
    if (cmd.mul) begin
      ph_r <= ph_nxt;
      pl_r <= pl_nxt;
    end
    if (cmd.pos) begin
      out_position       <= pos_nxt;
      out_turn_count     <= turns_r;
      out_phase_fraction <= pf_r;
    end
  end

endmodule

// File: rtl/iq_fringe_position_tracker.sv
// fringe position tracker: one word at a time, in_stall high until it is done; it takes the word,
// then runs 16 cordic rotations through a single shift-add unit, then fraction, multiply,
// filter and position steps; the position step waits while out_valid is held by out_stall.
// a finished result waits in the output register while the next word is taken.
// rst_n is synchronous: clears turn count, filter state and valid, gain returns to
// 1311 and zero offset to 0
module iq_fringe_position_tracker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_i_sample,
  input  logic [15:0]        in_q_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_position,
  output logic signed [23:0] out_turn_count,
  output logic signed [15:0] out_phase_fraction,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [16:0]        cfg_data
);
  import iqfpt_pkg::*;

  iqfpt_cmd_t cmd;

  iqfpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  iqfpt_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_i_sample        (in_i_sample),
    .in_q_sample        (in_q_sample),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_position       (out_position),
    .out_turn_count     (out_turn_count),
    .out_phase_fraction (out_phase_fraction)
  );

endmodule
